// ===== design/tvpsg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tvpsg_pkg
// register map, envelope shape table and shared constants of the sound generator
// ----------------------------------------------------------------------------
package tvpsg_pkg;

   localparam int CHANNELS_DEF = 3;
   localparam int MAX_CHANNELS = 3;

   // register map
   localparam logic [3:0] REG_TONE_A_LO = 4'd0;
   localparam logic [3:0] REG_NOISE     = 4'd6;
   localparam logic [3:0] REG_MIXER     = 4'd7;
   localparam logic [3:0] REG_VOL_A     = 4'd8;
   localparam logic [3:0] REG_ENV_LO    = 4'd11;
   localparam logic [3:0] REG_ENV_HI    = 4'd12;
   localparam logic [3:0] REG_SHAPE     = 4'd13;
   localparam int         REG_STORED    = 13;   // registers 0..12 kept as bytes

   // item kinds
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   localparam logic [16:0] LFSR_TAPS  = 17'h12000;
   localparam logic [16:0] LFSR_RESET = 17'h00001;
   localparam logic [5:0]  ENV_STEPS  = 6'd48;
   localparam logic [5:0]  ENV_LOOP   = 6'd16;

   typedef enum logic [1:0] {
      SEG_FALL = 2'd0,
      SEG_RISE = 2'd1,
      SEG_LOW  = 2'd2,
      SEG_HIGH = 2'd3
   } seg_kind_type;

   // segment kind for each shape and each sixteen-step segment
   function automatic seg_kind_type seg_kind(input logic [2:0] shape, input logic [1:0] seg);
      seg_kind_type k;
      k = SEG_FALL;
      case (shape)
         3'd0: k = SEG_FALL;
         3'd1: k = (seg == 2'd0) ? SEG_FALL : SEG_LOW;
         3'd2: k = (seg == 2'd1) ? SEG_RISE : SEG_FALL;
         3'd3: k = (seg == 2'd0) ? SEG_FALL : SEG_HIGH;
         3'd4: k = SEG_RISE;
         3'd5: k = (seg == 2'd0) ? SEG_RISE : SEG_HIGH;
         3'd6: k = (seg == 2'd1) ? SEG_FALL : SEG_RISE;
         default: k = (seg == 2'd0) ? SEG_RISE : SEG_LOW;
      endcase
      return k;
   endfunction

   function automatic logic [3:0] env_level(input logic [2:0] shape, input logic [5:0] step);
      logic [5:0]   s;
      logic [3:0]   lvl;
      seg_kind_type k;
      s = (step >= ENV_STEPS) ? (ENV_STEPS - 6'd1) : step;
      k = seg_kind(shape, s[5:4]);
      unique case (k)
         SEG_FALL: lvl = 4'd15 - s[3:0];
         SEG_RISE: lvl = s[3:0];
         SEG_LOW:  lvl = 4'd0;
         default:  lvl = 4'd15;
      endcase
      return lvl;
   endfunction

endpackage
`default_nettype wire

// ===== design/three_voice_tone_noise_envelope_psg_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// three_voice_tone_noise_envelope_psg_top
// three-voice tone, noise and envelope sound generator with one-item pipeline
// ----------------------------------------------------------------------------
// Each req item is either a register write (req_mode low) or one tick of the
// divided chip clock (req_mode high), and each one gives exactly one rsp item
// holding the three gated 4-bit channel levels taken after that item's effect.
// An item's tone, noise and envelope counters, the 17-bit noise shifter and
// the register file update in a single pass of logic, and the levels formed
// from the new state land in the result register, so the block takes a new
// item every cycle while req_stall is low. req_stall
// is only raised while a result is held and rsp_stall is high. Registers 0..5
// hold tone periods, 6 the noise period, 7 the mixer, 8..10 the volumes,
// 11 and 12 the envelope period, 13 the envelope shape; a zero period counts
// as one and writes to 14 or 15 are ignored. Channels at or above CHANNELS
// stay silent and their tone counters stand still.
// ----------------------------------------------------------------------------
module three_voice_tone_noise_envelope_psg_top #(
   parameter int CHANNELS = tvpsg_pkg::CHANNELS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_mode,
   input  wire logic [3:0] req_reg_addr,
   input  wire logic [7:0] req_reg_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [3:0]      rsp_level_a,
   output logic [3:0]      rsp_level_b,
   output logic [3:0]      rsp_level_c
);
   import tvpsg_pkg::*;

   // architectural state
   logic [7:0]  regs_ff     [REG_STORED];
   logic [7:0]  regs_in     [REG_STORED];
   logic [11:0] tone_cnt_ff [MAX_CHANNELS];
   logic [11:0] tone_cnt_in [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0] phase_ff, phase_in;
   logic [5:0]  noise_cnt_ff, noise_cnt_in;
   logic [16:0] lfsr_ff, lfsr_in;
   logic [16:0] env_cnt_ff, env_cnt_in;
   logic [5:0]  env_step_ff, env_step_in;
   logic [2:0]  shape_ff, shape_in;

   // result register
   logic        rsp_valid_ff;
   logic [3:0]  level_ff [MAX_CHANNELS];
   logic [3:0]  level_in [MAX_CHANNELS];

   logic        req_accept;

   // the result register frees as soon as its item is taken
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // next state for the item on the req side
   always_comb begin
      logic [11:0] tone_per;
      logic [11:0] tone_inc;
      logic [4:0]  noise_per;
      logic [5:0]  noise_inc;
      logic [15:0] env_per;
      logic [16:0] env_inc;
      logic [5:0]  step_inc;

      tone_per     = 12'd0;
      tone_inc     = 12'd0;
      noise_per    = 5'd0;
      noise_inc    = 6'd0;
      env_per      = 16'd0;
      env_inc      = 17'd0;
      step_inc     = 6'd0;

      regs_in      = regs_ff;
      tone_cnt_in  = tone_cnt_ff;
      phase_in     = phase_ff;
      noise_cnt_in = noise_cnt_ff;
      lfsr_in      = lfsr_ff;
      env_cnt_in   = env_cnt_ff;
      env_step_in  = env_step_ff;
      shape_in     = shape_ff;

      if (req_mode == MODE_TICK) begin
         // tone counters, each toggles its square phase on expiry
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            tone_per = {regs_ff[2*i+1][3:0], regs_ff[2*i]};
            if (tone_per == 12'd0) tone_per = 12'd1;
            tone_inc = tone_cnt_ff[i] + 12'd1;
            if (i < CHANNELS) begin
               if (tone_inc >= tone_per) begin
                  tone_cnt_in[i] = 12'd0;
                  phase_in[i]    = ~phase_ff[i];
               end else begin
                  tone_cnt_in[i] = tone_inc;
               end
            end
         end

         // noise counter runs at half rate against the period
         noise_per = regs_ff[REG_NOISE][4:0];
         if (noise_per == 5'd0) noise_per = 5'd1;
         noise_inc = noise_cnt_ff + 6'd1;
         if (noise_inc >= {noise_per, 1'b0}) begin
            noise_cnt_in = 6'd0;
            lfsr_in      = (lfsr_ff[0] ? LFSR_TAPS : 17'd0) ^ {1'b0, lfsr_ff[16:1]};
         end else begin
            noise_cnt_in = noise_inc;
         end

         // envelope counter and step index, looping back to the second segment
         env_per = {regs_ff[REG_ENV_HI], regs_ff[REG_ENV_LO]};
         if (env_per == 16'd0) env_per = 16'd1;
         env_inc = env_cnt_ff + 17'd1;
         if (env_inc >= {env_per, 1'b0}) begin
            env_cnt_in = 17'd0;
            step_inc   = env_step_ff + 6'd1;
            env_step_in = (step_inc >= ENV_STEPS) ? ENV_LOOP : step_inc;
         end else begin
            env_cnt_in = env_inc;
         end
      end else begin
         if (req_reg_addr == REG_SHAPE) begin
            // shapes without the continue bit fold onto their equivalents
            if (!req_reg_data[3]) shape_in = req_reg_data[2] ? 3'd7 : 3'd1;
            else                  shape_in = req_reg_data[2:0];
            env_step_in = 6'd0;
            env_cnt_in  = 17'd0;
         end else if (req_reg_addr < REG_SHAPE) begin
            regs_in[req_reg_addr] = req_reg_data;
         end
      end
   end

   // mixer and level select, from the state after this item
   always_comb begin
      logic [3:0] env_lvl;
      logic [7:0] vol;
      logic       tone_ok;
      logic       noise_ok;
      env_lvl = env_level(shape_in, env_step_in);
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         vol      = regs_in[int'(REG_VOL_A) + i];
         tone_ok  = regs_in[REG_MIXER][i]   | phase_in[i];
         noise_ok = regs_in[REG_MIXER][i+3] | lfsr_in[0];
         if ((i < CHANNELS) && tone_ok && noise_ok) begin
            level_in[i] = vol[4] ? env_lvl : vol[3:0];
         end else begin
            level_in[i] = 4'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < REG_STORED; r++) regs_ff[r] <= 8'd0;
         for (int i = 0; i < MAX_CHANNELS; i++) tone_cnt_ff[i] <= 12'd0;
         phase_ff     <= '0;
         noise_cnt_ff <= 6'd0;
         lfsr_ff      <= LFSR_RESET;
         env_cnt_ff   <= 17'd0;
         env_step_ff  <= 6'd0;
         shape_ff     <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            regs_ff      <= regs_in;
            tone_cnt_ff  <= tone_cnt_in;
            phase_ff     <= phase_in;
            noise_cnt_ff <= noise_cnt_in;
            lfsr_ff      <= lfsr_in;
            env_cnt_ff   <= env_cnt_in;
            env_step_ff  <= env_step_in;
            shape_ff     <= shape_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         level_ff <= level_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_level_a = level_ff[0];
   assign rsp_level_b = level_ff[1];
   assign rsp_level_c = level_ff[2];

endmodule
`default_nettype wire
